[rtl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg: shared types and widths for the sphere against cylinder test
// Holds the coordinate width, the widths derived from it and the request
// and sideband types used between the pipeline sections.
// ----------------------------------------------------------------------------
package scc_pkg;

    // Coordinate width in bits; the format is signed Q.8 (valid 12 to 32).
    localparam int COORD_BITS = 24;

    // Unsigned quantities (radii, extents, height) are one bit narrower.
    localparam int RAD_BITS   = COORD_BITS - 1;
    // Axis position and top of the cylinder.
    localparam int AXIS_BITS  = COORD_BITS + 1;
    // Signed horizontal delta and its magnitude.
    localparam int DIFF_BITS  = COORD_BITS + 2;
    localparam int MAG_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    // Vertical gap magnitude.
    localparam int VGAP_BITS  = COORD_BITS;
    // Square root: result width and the (even) radicand width.
    localparam int ROOT_BITS  = MAG_BITS + 1;
    localparam int RADICAND_BITS = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 1;
    // Squares in the final comparison.
    localparam int RSQ_BITS   = 2 * RAD_BITS;

    // Stream widths.
    localparam int IN_BITS        = 6 * COORD_BITS + 5 * RAD_BITS;
    localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = 8;

    // One input request, first field in the lowest bits.
    typedef struct packed {
        logic        [RAD_BITS-1:0]   body_height;
        logic        [RAD_BITS-1:0]   body_radius;
        logic        [RAD_BITS-1:0]   body_depth;
        logic        [RAD_BITS-1:0]   body_width;
        logic signed [COORD_BITS-1:0] body_corner_z;
        logic signed [COORD_BITS-1:0] body_base_y;
        logic signed [COORD_BITS-1:0] body_corner_x;
        logic        [RAD_BITS-1:0]   sphere_radius;
        logic signed [COORD_BITS-1:0] sphere_z;
        logic signed [COORD_BITS-1:0] sphere_y;
        logic signed [COORD_BITS-1:0] sphere_x;
    } in_item_t;

    // Values that travel alongside the square root.
    typedef struct packed {
        logic [VGAP_BITS-1:0] vgap;
        logic [RAD_BITS-1:0]  rs;
        logic [RAD_BITS-1:0]  rc;
    } side_t;

endpackage

[rtl/scc_front.sv]
// ----------------------------------------------------------------------------
// scc_front: geometry front end
// Four stages: axis and top, deltas and vertical gap, squares, and the sum
// of squares that feeds the square root.
// ----------------------------------------------------------------------------
module scc_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic                               in_valid,
    input  scc_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    output logic [scc_pkg::RADICAND_BITS-1:0]  out_rad,
    output scc_pkg::side_t                     out_side
);
    import scc_pkg::*;

    // Stage A registers.
    logic                        a_valid_reg;
    logic signed [COORD_BITS-1:0] a_sx_reg, a_sy_reg, a_sz_reg, a_by_reg;
    logic signed [AXIS_BITS-1:0]  a_ax_reg, a_az_reg, a_top_reg;
    logic signed [AXIS_BITS-1:0]  a_ax_next, a_az_next, a_top_next;
    logic [RAD_BITS-1:0]          a_rs_reg, a_rc_reg;

    // Stage B registers.
    logic                 b_valid_reg;
    logic [MAG_BITS-1:0]  b_dxm_reg, b_dzm_reg, b_dxm_next, b_dzm_next;
    side_t                b_side_reg, b_side_next;

    // Stage C registers.
    logic                 c_valid_reg;
    logic [SQ_BITS-1:0]   c_sqx_reg, c_sqz_reg, c_sqx_next, c_sqz_next;
    side_t                c_side_reg;

    // Stage D registers.
    logic                      d_valid_reg;
    logic [RADICAND_BITS-1:0]  d_rad_reg, d_rad_next;
    side_t                     d_side_reg;

    // Stage B working signals.
    logic signed [DIFF_BITS-1:0] dx, dz;
    logic        [DIFF_BITS-1:0] dx_neg, dz_neg;
    logic signed [AXIS_BITS-1:0] sy_e, by_e;
    logic        [AXIS_BITS-1:0] vg_wide;

    // Axis position at corner plus half extent, and top of the cylinder.
    always_comb begin
        a_ax_next  = {in_item.body_corner_x[COORD_BITS-1], in_item.body_corner_x}
                   + {3'b000, in_item.body_width[RAD_BITS-1:1]};
        a_az_next  = {in_item.body_corner_z[COORD_BITS-1], in_item.body_corner_z}
                   + {3'b000, in_item.body_depth[RAD_BITS-1:1]};
        a_top_next = {in_item.body_base_y[COORD_BITS-1], in_item.body_base_y}
                   + {2'b00, in_item.body_height};
    end

    // Horizontal delta magnitudes and the vertical gap after clamping.
    always_comb begin
        dx     = {{2{a_sx_reg[COORD_BITS-1]}}, a_sx_reg} - {a_ax_reg[AXIS_BITS-1], a_ax_reg};
        dz     = {{2{a_sz_reg[COORD_BITS-1]}}, a_sz_reg} - {a_az_reg[AXIS_BITS-1], a_az_reg};
        dx_neg = {DIFF_BITS{1'b0}} - dx;
        dz_neg = {DIFF_BITS{1'b0}} - dz;
        b_dxm_next = dx[DIFF_BITS-1] ? dx_neg[MAG_BITS-1:0] : dx[MAG_BITS-1:0];
        b_dzm_next = dz[DIFF_BITS-1] ? dz_neg[MAG_BITS-1:0] : dz[MAG_BITS-1:0];

        sy_e = {a_sy_reg[COORD_BITS-1], a_sy_reg};
        by_e = {a_by_reg[COORD_BITS-1], a_by_reg};
        if (sy_e < by_e) begin
            vg_wide = by_e - sy_e;
        end else if (sy_e > a_top_reg) begin
            vg_wide = sy_e - a_top_reg;
        end else begin
            vg_wide = {AXIS_BITS{1'b0}};
        end
        b_side_next.vgap = vg_wide[VGAP_BITS-1:0];
        b_side_next.rs   = a_rs_reg;
        b_side_next.rc   = a_rc_reg;
    end

    // Squares of the horizontal deltas.
    always_comb begin
        c_sqx_next = b_dxm_reg * b_dxm_reg;
        c_sqz_next = b_dzm_reg * b_dzm_reg;
    end

    // Sum of squares, widened to the radicand.
    always_comb begin
        d_rad_next = {2'b00, c_sqx_reg} + {2'b00, c_sqz_reg};
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_sx_reg   <= in_item.sphere_x;
            a_sy_reg   <= in_item.sphere_y;
            a_sz_reg   <= in_item.sphere_z;
            a_by_reg   <= in_item.body_base_y;
            a_ax_reg   <= a_ax_next;
            a_az_reg   <= a_az_next;
            a_top_reg  <= a_top_next;
            a_rs_reg   <= in_item.sphere_radius;
            a_rc_reg   <= in_item.body_radius;
            b_dxm_reg  <= b_dxm_next;
            b_dzm_reg  <= b_dzm_next;
            b_side_reg <= b_side_next;
            c_sqx_reg  <= c_sqx_next;
            c_sqz_reg  <= c_sqz_next;
            c_side_reg <= b_side_reg;
            d_rad_reg  <= d_rad_next;
            d_side_reg <= c_side_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_rad   = d_rad_reg;
    assign out_side  = d_side_reg;

endmodule

[rtl/scc_sqrt.sv]
// ----------------------------------------------------------------------------
// scc_sqrt: pipelined integer square root
// Restoring digit-by-digit square root, one result bit per stage, giving the
// floor of the root of the radicand. The sideband travels alongside.
// ----------------------------------------------------------------------------
module scc_sqrt (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic [scc_pkg::RADICAND_BITS-1:0]  in_rad,
    input  scc_pkg::side_t                     in_side,
    output logic                               out_valid,
    output logic [scc_pkg::ROOT_BITS-1:0]      out_root,
    output scc_pkg::side_t                     out_side
);
    import scc_pkg::*;

    // Per-stage registers.
    logic                     valid_reg [ROOT_BITS];
    logic [REM_BITS-1:0]      rem_reg   [ROOT_BITS];
    logic [ROOT_BITS-1:0]     root_reg  [ROOT_BITS];
    logic [RADICAND_BITS-1:0] rad_reg   [ROOT_BITS];
    side_t                    side_reg  [ROOT_BITS];

    // Per-stage inputs and next values.
    logic                     valid_in  [ROOT_BITS];
    logic [REM_BITS-1:0]      rem_in    [ROOT_BITS];
    logic [ROOT_BITS-1:0]     root_in   [ROOT_BITS];
    logic [RADICAND_BITS-1:0] rad_in    [ROOT_BITS];
    side_t                    side_in   [ROOT_BITS];
    logic [REM_BITS+1:0]      shifted   [ROOT_BITS];
    logic [REM_BITS+1:0]      trial     [ROOT_BITS];
    logic [REM_BITS+1:0]      diff      [ROOT_BITS];
    logic                     take      [ROOT_BITS];
    logic [REM_BITS-1:0]      rem_next  [ROOT_BITS];
    logic [ROOT_BITS-1:0]     root_next [ROOT_BITS];

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        // Stage input: the module input for the first stage.
        if (k == 0) begin : g_first
            assign valid_in[k] = in_valid;
            assign rem_in[k]   = {REM_BITS{1'b0}};
            assign root_in[k]  = {ROOT_BITS{1'b0}};
            assign rad_in[k]   = in_rad;
            assign side_in[k]  = in_side;
        end else begin : g_rest
            assign valid_in[k] = valid_reg[k-1];
            assign rem_in[k]   = rem_reg[k-1];
            assign root_in[k]  = root_reg[k-1];
            assign rad_in[k]   = rad_reg[k-1];
            assign side_in[k]  = side_reg[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign shifted[k]   = {rem_in[k], rad_in[k][RADICAND_BITS-1:RADICAND_BITS-2]};
        assign trial[k]     = {1'b0, root_in[k], 2'b01};
        assign diff[k]      = shifted[k] - trial[k];
        assign take[k]      = (shifted[k] >= trial[k]);
        assign rem_next[k]  = take[k] ? diff[k][REM_BITS-1:0] : shifted[k][REM_BITS-1:0];
        assign root_next[k] = {root_in[k][ROOT_BITS-2:0], take[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= valid_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= {rad_in[k][RADICAND_BITS-3:0], 2'b00};
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_BITS-1];
    assign out_root  = root_reg[ROOT_BITS-1];
    assign out_side  = side_reg[ROOT_BITS-1];

endmodule

[rtl/scc_judge.sv]
// ----------------------------------------------------------------------------
// scc_judge: gap squares and the final hit decision
// Three stages: horizontal gap and range checks, the three squares, and the
// comparison of the summed gap squares with the sphere radius squared.
// ----------------------------------------------------------------------------
module scc_judge (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic [scc_pkg::ROOT_BITS-1:0]  in_dist,
    input  scc_pkg::side_t                 in_side,
    output logic                           out_valid,
    output logic                           out_hit
);
    import scc_pkg::*;

    // Stage E registers.
    logic                  e_valid_reg, e_near_reg, e_near_next;
    logic [RAD_BITS-1:0]   e_hg_reg, e_vg_reg, e_rs_reg;
    logic [ROOT_BITS-1:0]  hgap, rc_e;

    // Stage F registers.
    logic                  f_valid_reg, f_near_reg;
    logic [RSQ_BITS-1:0]   f_hsq_reg, f_vsq_reg, f_rsq_reg;
    logic [RSQ_BITS-1:0]   f_hsq_next, f_vsq_next, f_rsq_next;

    // Stage G registers.
    logic                  g_valid_reg, g_hit_reg, g_hit_next;

    // Horizontal gap floored at zero; both gaps must lie within the radius.
    always_comb begin
        rc_e = {{(ROOT_BITS-RAD_BITS){1'b0}}, in_side.rc};
        hgap = (in_dist > rc_e) ? (in_dist - rc_e) : {ROOT_BITS{1'b0}};
        e_near_next = (hgap <= {{(ROOT_BITS-RAD_BITS){1'b0}}, in_side.rs})
                   && (in_side.vgap <= {{(VGAP_BITS-RAD_BITS){1'b0}}, in_side.rs});
    end

    // Squares of both gaps and of the sphere radius.
    always_comb begin
        f_hsq_next = e_hg_reg * e_hg_reg;
        f_vsq_next = e_vg_reg * e_vg_reg;
        f_rsq_next = e_rs_reg * e_rs_reg;
    end

    // Final comparison.
    always_comb begin
        g_hit_next = f_near_reg
                  && (({1'b0, f_hsq_reg} + {1'b0, f_vsq_reg}) <= {1'b0, f_rsq_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= in_valid;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
        end
    end

    // Gaps are only meaningful below the radius, so they are cut to its width.
    always_ff @(posedge aclk) begin
        if (adv) begin
            e_near_reg <= e_near_next;
            e_hg_reg   <= hgap[RAD_BITS-1:0];
            e_vg_reg   <= in_side.vgap[RAD_BITS-1:0];
            e_rs_reg   <= in_side.rs;
            f_near_reg <= e_near_reg;
            f_hsq_reg  <= f_hsq_next;
            f_vsq_reg  <= f_vsq_next;
            f_rsq_reg  <= f_rsq_next;
            g_hit_reg  <= g_hit_next;
        end
    end

    assign out_valid = g_valid_reg;
    assign out_hit   = g_hit_reg;

endmodule

[rtl/scc_out.sv]
// ----------------------------------------------------------------------------
// scc_out: output register with skid stage
// Holds the result on the master side and catches one more while the sink
// stalls; the pipeline advances whenever the skid stage is empty.
// ----------------------------------------------------------------------------
module scc_out (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  logic                                 in_hit,
    output logic                                 adv,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [scc_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);
    import scc_pkg::*;

    logic out_valid_reg, out_valid_next, out_hit_reg, out_hit_next;
    logic skid_valid_reg, skid_valid_next, skid_hit_reg, skid_hit_next;
    logic push, out_free;

    assign adv      = !skid_valid_reg;
    assign push     = in_valid && adv;
    assign out_free = !out_valid_reg || m_tready;

    // Refill the output from the skid stage first, else from the pipeline.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_hit_next    = out_hit_reg;
        skid_valid_next = skid_valid_reg;
        skid_hit_next   = skid_hit_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_hit_next    = skid_hit_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next  = push;
                out_hit_next    = in_hit;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_hit_next   = in_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_hit_reg  <= out_hit_next;
        skid_hit_reg <= skid_hit_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_BITS-1){1'b0}}, out_hit_reg};

endmodule

[rtl/sphere_cylinder_collision.sv]
// The block tests one sphere against one upright cylinder per request and
// returns one hit flag per request, in order. It takes a new request in every
// clock cycle while s_tready is high. A request passes through four front-end
// stages, the square-root pipeline, which resolves one root bit per stage,
// three decision stages and the output register. The result side holds one
// finished result and catches one more while m_tready is low; only after
// both are occupied does s_tready fall.
// ----------------------------------------------------------------------------
// sphere_cylinder_collision: sphere against upright cylinder contact test
// Axis and clamp arithmetic, pipelined square root of the axis distance,
// gap squares and the final comparison, then the output register.
// ----------------------------------------------------------------------------
module sphere_cylinder_collision (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sphere_x, sphere_y, sphere_z, sphere_radius, body_corner_x, body_base_y,
    // body_corner_z, body_width, body_depth, body_radius, body_height
    input  logic [scc_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit
    output logic [scc_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);
    import scc_pkg::*;

    in_item_t                 item;
    logic                     adv;
    logic                     fr_valid, sq_valid, jd_valid, jd_hit;
    logic [RADICAND_BITS-1:0] fr_rad;
    logic [ROOT_BITS-1:0]     sq_root;
    side_t                    fr_side, sq_side;

    // Unpack the request; padding bits above the fields are ignored.
    assign item     = s_tdata[IN_BITS-1:0];
    assign s_tready = adv;

    scc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_item   (item),
        .out_valid (fr_valid),
        .out_rad   (fr_rad),
        .out_side  (fr_side)
    );

    scc_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_rad    (fr_rad),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    scc_judge u_judge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_dist   (sq_root),
        .in_side   (sq_side),
        .out_valid (jd_valid),
        .out_hit   (jd_hit)
    );

    scc_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (jd_valid),
        .in_hit    (jd_hit),
        .adv       (adv),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/scc_checker.sv]
// ----------------------------------------------------------------------------
// scc_checker: port-level checks for the collision test block
// Watches the handshakes on both sides and the result padding over time.
// ----------------------------------------------------------------------------
module scc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [scc_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [scc_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);
    import scc_pkg::*;

    // A stalled result stays offered and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or was withdrawn");

    // The padding above the hit flag is always zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_BITS-1:1] == '0))
        else $error("result padding bits set");

    // Back-pressure on the input only arises with a result waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // The skid stage only fills after a stalled result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without a stall on the result side");

endmodule

bind sphere_cylinder_collision scc_checker u_scc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/tb_sphere_cylinder_collision.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_cylinder_collision: stream testbench for the sphere/cylinder test
// Drives contact requests through the input stream and checks each hit flag
// against an in-bench model of the geometry. A table of directed geometries
// comes first. Random requests follow, mostly placed close to the cylinder,
// while both sides idle, stall and hold off at random.
// ----------------------------------------------------------------------------
module tb_sphere_cylinder_collision;

    import scc_pkg::*;

    localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -(64'sd1 <<< (COORD_BITS - 1));
    localparam longint RAD_MAX   = (64'sd1 <<< RAD_BITS) - 1;
    // Acceptance to result of the block, used to size the final drain wait.
    localparam int     LATENCY   = COORD_BITS + 10;
    localparam int     RANDOM_PER_PHASE = 510;
    localparam int     HOLD_CYCLES      = 400;

    // One row of the directed table: the request and, where it is obvious,
    // the hit flag that it must give.
    typedef struct packed {
        in_item_t item;
        logic     known;
        logic     hit;
    } probe_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    logic   hit_expected[$];
    probe_t directed_rows[$];
    int     tx_idle_pct;
    int     rx_idle_pct;
    int     hold_left;
    int     errors;
    int     requests_sent;
    int     hits_seen;
    int     misses_seen;
    int     stalled_cycles;

    sphere_cylinder_collision dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit, well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Floor of the square root of a non-negative value below 2^54.
    function automatic longint root_floor(input longint d);
        longint r;
        longint t;
        r = 0;
        for (int b = 27; b >= 0; b--) begin
            t = r | (64'sd1 <<< b);
            if (t * t <= d) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Horizontal gap to the side surface (floored at zero inside the
    // cylinder) and vertical gap to the clamped height span.
    function automatic void contact_gaps(input in_item_t it, output longint hgap,
                                         output longint vgap);
        longint sx, sy, sz, cx, by, cz, w, dp, rc, h;
        longint ax, az, top, py, dx, dz, axis_dist;
        sx = $signed(it.sphere_x);
        sy = $signed(it.sphere_y);
        sz = $signed(it.sphere_z);
        cx = $signed(it.body_corner_x);
        by = $signed(it.body_base_y);
        cz = $signed(it.body_corner_z);
        w  = it.body_width;
        dp = it.body_depth;
        rc = it.body_radius;
        h  = it.body_height;
        ax  = cx + (w >>> 1);
        az  = cz + (dp >>> 1);
        top = by + h;
        py  = (sy < by) ? by : ((sy > top) ? top : sy);
        vgap = (sy > py) ? sy - py : py - sy;
        dx   = (sx > ax) ? sx - ax : ax - sx;
        dz   = (sz > az) ? sz - az : az - sz;
        axis_dist = root_floor(dx * dx + dz * dz);
        hgap = (axis_dist > rc) ? axis_dist - rc : 0;
    endfunction

    // Expected hit flag for one request.
    function automatic logic predict_hit(input in_item_t it);
        longint hg, vg, rs;
        contact_gaps(it, hg, vg);
        rs = it.sphere_radius;
        return (hg <= rs) && (vg <= rs) && (hg * hg + vg * vg <= rs * rs);
    endfunction

    // Builds a request from plain integers; values are cut to field width.
    function automatic in_item_t shape(input longint sx, sy, sz, rs, cx, by, cz,
                                       w, dp, rc, h);
        in_item_t it;
        it.sphere_x      = sx[COORD_BITS-1:0];
        it.sphere_y      = sy[COORD_BITS-1:0];
        it.sphere_z      = sz[COORD_BITS-1:0];
        it.sphere_radius = rs[RAD_BITS-1:0];
        it.body_corner_x = cx[COORD_BITS-1:0];
        it.body_base_y   = by[COORD_BITS-1:0];
        it.body_corner_z = cz[COORD_BITS-1:0];
        it.body_width    = w[RAD_BITS-1:0];
        it.body_depth    = dp[RAD_BITS-1:0];
        it.body_radius   = rc[RAD_BITS-1:0];
        it.body_height   = h[RAD_BITS-1:0];
        return it;
    endfunction

    // Random request: some are raw bit patterns, most place the sphere near a
    // cylinder of random scale, and a share of those sit right at contact.
    function automatic in_item_t random_request();
        in_item_t it;
        longint   span, cx, by, cz, w, dp, rc, h, sx, sy, sz, rs, hg, vg;
        if ($urandom_range(0, 99) < 15) begin
            it = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
            return it;
        end
        span = 64'sd1 <<< $urandom_range(2, 21);
        cx = longint'($urandom_range(0, 32'h7F_FFFF)) - 64'sd4194304;
        by = longint'($urandom_range(0, 32'h7F_FFFF)) - 64'sd4194304;
        cz = longint'($urandom_range(0, 32'h7F_FFFF)) - 64'sd4194304;
        w  = $urandom_range(0, 32'(2 * span));
        dp = $urandom_range(0, 32'(2 * span));
        rc = $urandom_range(0, 32'(span));
        h  = $urandom_range(0, 32'(2 * span));
        sx = cx + (w >>> 1) + longint'($urandom_range(0, 32'(4 * span))) - 2 * span;
        sz = cz + (dp >>> 1) + longint'($urandom_range(0, 32'(4 * span))) - 2 * span;
        sy = by + longint'($urandom_range(0, 32'(h + 2 * span))) - span;
        rs = $urandom_range(0, 32'(span));
        it = shape(sx, sy, sz, rs, cx, by, cz, w, dp, rc, h);
        // Put the surface exactly on the contact distance, or one step past.
        if ($urandom_range(0, 3) == 0) begin
            contact_gaps(it, hg, vg);
            rs = root_floor(hg * hg + vg * vg) + longint'($urandom_range(0, 1));
            if (rs > RAD_MAX) begin
                rs = RAD_MAX;
            end
            it.sphere_radius = rs[RAD_BITS-1:0];
        end
        return it;
    endfunction

    // Offers one request, idling first at the current rate, and records the
    // expected flag once the block has taken it.
    task automatic send_request(input in_item_t it, input logic known,
                                input logic typed_hit);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_TDATA_BITS'({$urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom, $urandom,
                                        $urandom});
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_BITS'(it);
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        hit_expected.push_back(known ? typed_hit : predict_hit(it));
        requests_sent++;
    endtask

    // Result side: random back-pressure, or a long hold when one is asked.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Result checking against the oldest outstanding expectation.
    always @(posedge aclk) begin
        logic exp_hit;
        if (aresetn && s_tvalid && !s_tready) begin
            stalled_cycles++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tdata[0]) begin
                hits_seen++;
            end else begin
                misses_seen++;
            end
            if (m_tdata[OUT_TDATA_BITS-1:1] != '0) begin
                $error("m_tdata padding: expected 0, actual %0h",
                       m_tdata[OUT_TDATA_BITS-1:1]);
                errors++;
            end
            if (hit_expected.size() == 0) begin
                $error("hit: expected none, actual %0d", m_tdata[0]);
                errors++;
            end else begin
                exp_hit = hit_expected.pop_front();
                if (m_tdata[0] !== exp_hit) begin
                    $error("hit: expected %0d, actual %0d", exp_hit, m_tdata[0]);
                    errors++;
                end
            end
        end
    end

    // Directed table.
    initial begin
        // Everything at the origin: zero radius touches at zero gap.
        directed_rows.push_back(probe_t'{shape(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                         1'b1, 1'b1});
        // Centre inside the cylinder, on the axis and off it.
        directed_rows.push_back(probe_t'{shape(0, 'h100, 0, 0, -'h400, 0, -'h400,
                                               'h800, 'h800, 'h400, 'h1000), 1'b1, 1'b1});
        directed_rows.push_back(probe_t'{shape('h200, 'h100, 0, 0, -'h400, 0, -'h400,
                                               'h800, 'h800, 'h400, 'h1000), 1'b1, 1'b1});
        // Above the top: one radius short, then touching.
        directed_rows.push_back(probe_t'{shape(0, 'h2000, 0, 'h800, -'h400, 0, -'h400,
                                               'h800, 'h800, 'h400, 'h1000), 1'b1, 1'b0});
        directed_rows.push_back(probe_t'{shape(0, 'h1800, 0, 'h800, -'h400, 0, -'h400,
                                               'h800, 'h800, 'h400, 'h1000), 1'b1, 1'b1});
        // Below the base: one step out, then touching.
        directed_rows.push_back(probe_t'{shape(0, -'h801, 0, 'h800, -'h400, 0, -'h400,
                                               'h800, 'h800, 'h400, 'h1000), 1'b1, 1'b0});
        directed_rows.push_back(probe_t'{shape(0, -'h800, 0, 'h800, -'h400, 0, -'h400,
                                               'h800, 'h800, 'h400, 'h1000), 1'b1, 1'b1});
        // Beside the side surface: touching, then one step short.
        directed_rows.push_back(probe_t'{shape('h1000, 'h800, 0, 'hC00, -'h400, 0,
                                               -'h400, 'h800, 'h800, 'h400, 'h1000),
                                         1'b1, 1'b1});
        directed_rows.push_back(probe_t'{shape('h1000, 'h800, 0, 'hBFF, -'h400, 0,
                                               -'h400, 'h800, 'h800, 'h400, 'h1000),
                                         1'b1, 1'b0});
        // Diagonal distance with an exact root against a thin axis line.
        directed_rows.push_back(probe_t'{shape('h300, 'h800, 'h400, 'h500, -'h400, 0,
                                               -'h400, 'h800, 'h800, 0, 'h1000), 1'b1, 1'b1});
        directed_rows.push_back(probe_t'{shape('h300, 'h800, 'h400, 'h4FF, -'h400, 0,
                                               -'h400, 'h800, 'h800, 0, 'h1000), 1'b1, 1'b0});
        // Root that is not exact, so the floor decides.
        directed_rows.push_back(probe_t'{shape(1, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0),
                                         1'b0, 1'b0});
        directed_rows.push_back(probe_t'{shape(1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0),
                                         1'b0, 1'b0});
        // Odd extents: the half is truncated.
        directed_rows.push_back(probe_t'{shape(1, 0, 1, 1, 0, 0, 0, 1, 1, 0, 0),
                                         1'b0, 1'b0});
        directed_rows.push_back(probe_t'{shape(1, 0, 0, 0, 0, 0, 0, 3, 3, 0, 0),
                                         1'b0, 1'b0});
        // Opposite corners of the coordinate range: far out of reach.
        directed_rows.push_back(probe_t'{shape(COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX,
                                               COORD_MAX, COORD_MAX, COORD_MAX,
                                               0, 0, 0, 0), 1'b1, 1'b0});
        // Every field at its top or bottom value.
        directed_rows.push_back(probe_t'{shape(COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX,
                                               COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX,
                                               RAD_MAX, RAD_MAX, RAD_MAX), 1'b0, 1'b0});
        directed_rows.push_back(probe_t'{shape(COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX,
                                               COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX,
                                               RAD_MAX, RAD_MAX, RAD_MAX), 1'b0, 1'b0});
        directed_rows.push_back(probe_t'{shape(COORD_MIN, COORD_MAX, COORD_MIN, RAD_MAX,
                                               COORD_MAX, COORD_MIN, COORD_MAX, RAD_MAX,
                                               RAD_MAX, RAD_MAX, RAD_MAX), 1'b0, 1'b0});
        directed_rows.push_back(probe_t'{shape(COORD_MAX, COORD_MIN, COORD_MAX, 0,
                                               COORD_MIN, COORD_MAX, COORD_MIN, 0,
                                               0, 0, 0), 1'b0, 1'b0});
        // A huge sphere around a small cylinder, and a flat cylinder.
        directed_rows.push_back(probe_t'{shape(0, 0, 0, RAD_MAX, 'h1000, 'h1000, 'h1000,
                                               'h100, 'h100, 'h80, 'h100), 1'b0, 1'b0});
        directed_rows.push_back(probe_t'{shape(0, 'h500, 'h2000, 'h100, -'h100, 'h480,
                                               'h1E00, 'h200, 'h200, 'h100, 0), 1'b0, 1'b0});
    end

    // Reset, then the directed table and three phases of random requests.
    initial begin
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        tx_idle_pct = 31;
        rx_idle_pct = 82;
        hold_left   = 0;
        errors      = 0;
        requests_sent  = 0;
        hits_seen      = 0;
        misses_seen    = 0;
        stalled_cycles = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].item, directed_rows[i].known,
                         directed_rows[i].hit);
        end
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_request(random_request(), 1'b0, 1'b0);
        end

        tx_idle_pct = 82;
        rx_idle_pct = 31;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_request(random_request(), 1'b0, 1'b0);
        end

        // Full rate; the result side starts with a long hold so that the
        // pipeline fills and the input side has to stall.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left   = HOLD_CYCLES;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_request(random_request(), 1'b0, 1'b0);
        end
        s_tvalid <= 1'b0;

        // Drain, then watch for stray results for a while.
        while (hit_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2 * LATENCY) @(posedge aclk);
        if (hit_expected.size() != 0) begin
            $error("results outstanding: expected 0, actual %0d", hit_expected.size());
            errors++;
        end

        $display("Covered %0d contact requests (%0d from the table): %0d hits, %0d misses.",
                 requests_sent, directed_rows.size(), hits_seen, misses_seen);
        $display("The input side was held back for %0d cycles by result back-pressure.",
                 stalled_cycles);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
